// File: sv/grid_radius_enemy_scan_top_defines.svh
// assertion macros used by the grid scan datapath
`ifndef GRID_RADIUS_ENEMY_SCAN_TOP_DEFINES_SVH
`define GRID_RADIUS_ENEMY_SCAN_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define GRES_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gres assertion failed");

// next-cycle implication, checked outside reset
`define GRES_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gres assertion failed");

`endif

// File: sv/gres_pkg.sv
// shared types, constants and width helpers for the grid radius scan
package gres_pkg;

  localparam int unsigned GRID_SIDE_MAX_DEF = 64;
  localparam int unsigned ID_BITS_DEF       = 8;
  localparam int unsigned TEAM_BITS_DEF     = 2;
  localparam int unsigned VISION_MAX_DEF    = 4;

  localparam int unsigned VISION_RST = 2;
  localparam int unsigned CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH  = 3'd0,
    CFG_GRID_HEIGHT = 3'd1,
    CFG_VISION_RAD  = 3'd2,
    CFG_OWN_ID      = 3'd3,
    CFG_OWN_TEAM    = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_SCAN  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic clear;
    logic write_cell;
    logic load_scan;
    logic step;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic scan_inside;
    logic walk_last;
    logic scan_end;
  } dp_sts_t;

  function automatic int unsigned max2(input int unsigned a, input int unsigned b);
    return (a > b) ? a : b;
  endfunction

  function automatic int unsigned rad_w(input int unsigned vision_max);
    return max2($clog2(2 * vision_max), 2);
  endfunction

  function automatic int unsigned cfg_w(input int unsigned side_max,
                                        input int unsigned id_bits,
                                        input int unsigned team_bits,
                                        input int unsigned vision_max);
    return max2(max2($clog2(side_max + 1), id_bits),
                max2(team_bits, rad_w(vision_max)));
  endfunction

endpackage

// File: sv/gres_ctrl.sv
// controller state machine: clearing pass, request accept, window walk, drain
module gres_ctrl
  import gres_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  input  logic    command_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o,
  output logic    busy
);

  state_e state_q, state_d;
  logic   accept;

  assign accept = start && (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (sts_i.clear_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        // an observer outside the grid gives no results and no walk
        if (accept && (cmd_e'(command_i) == CMD_SCAN) && sts_i.scan_inside) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.walk_last) state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (sts_i.scan_end) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o.clear      = (state_q == ST_CLEAR);
    cmd_o.write_cell = accept && (cmd_e'(command_i) == CMD_WRITE);
    cmd_o.load_scan  = accept && (cmd_e'(command_i) == CMD_SCAN);
    cmd_o.step       = (state_q == ST_SCAN);
    busy             = (state_q != ST_IDLE);
  end

endmodule

// File: sv/gres_dp.sv
// datapath: config registers, grid memory, window walk and result staging
module gres_dp
  import gres_pkg::*;
#(
  parameter int unsigned GRID_SIDE_MAX = GRID_SIDE_MAX_DEF,
  parameter int unsigned ID_BITS       = ID_BITS_DEF,
  parameter int unsigned TEAM_BITS     = TEAM_BITS_DEF,
  parameter int unsigned VISION_MAX    = VISION_MAX_DEF,
  localparam int unsigned PosW  = $clog2(GRID_SIDE_MAX),
  localparam int unsigned CfgW  = cfg_w(GRID_SIDE_MAX, ID_BITS, TEAM_BITS, VISION_MAX)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dp_cmd_t                cmd_i,
  output dp_sts_t                sts_o,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CfgW-1:0]        cfg_wdata_i,
  input  logic [PosW-1:0]        pos_x_i,
  input  logic [PosW-1:0]        pos_y_i,
  input  logic signed [ID_BITS:0] cell_entity_i,
  input  logic [TEAM_BITS-1:0]   cell_team_i,
  output logic                   valid_o,
  output logic [ID_BITS-1:0]     enemy_id_o,
  output logic [ID_BITS-1:0]     sender_id_o,
  output logic                   last_o
);

  `include "grid_radius_enemy_scan_top_defines.svh"

  localparam int unsigned SideW = $clog2(GRID_SIDE_MAX + 1);
  localparam int unsigned RadW  = rad_w(VISION_MAX);
  localparam int unsigned Depth = GRID_SIDE_MAX * GRID_SIDE_MAX;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CellW = ID_BITS + TEAM_BITS + 1;
  localparam int unsigned CoordW = $clog2(GRID_SIDE_MAX + VISION_MAX + 1);
  localparam int unsigned SqW   = 2 * (PosW + 1);
  localparam int unsigned CmpW  = max2(SqW + 1, 2 * RadW);

  // configuration registers
  logic [SideW-1:0]     grid_w_q, grid_h_q;
  logic [RadW-1:0]      rad_q;
  logic [ID_BITS-1:0]   own_id_q;
  logic [TEAM_BITS-1:0] own_team_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_w_q   <= SideW'(GRID_SIDE_MAX);
      grid_h_q   <= SideW'(GRID_SIDE_MAX);
      rad_q      <= RadW'(VISION_RST);
      own_id_q   <= '0;
      own_team_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_GRID_WIDTH:  grid_w_q   <= cfg_wdata_i[SideW-1:0];
        CFG_GRID_HEIGHT: grid_h_q   <= cfg_wdata_i[SideW-1:0];
        CFG_VISION_RAD:  rad_q      <= cfg_wdata_i[RadW-1:0];
        CFG_OWN_ID:      own_id_q   <= cfg_wdata_i[ID_BITS-1:0];
        CFG_OWN_TEAM:    own_team_q <= cfg_wdata_i[TEAM_BITS-1:0];
        default: ;
      endcase
    end
  end

  // window setup from the scan request
  logic [SideW-1:0]  w_sat, h_sat;
  logic [RadW-1:0]   r_sat;
  logic              obs_in_grid;
  logic [CoordW-1:0] px_c, py_c, r_c, wm1, hm1;
  logic [CoordW-1:0] x0_c, x1_c, y0_c, y1_c;

  always_comb begin
    w_sat  = (grid_w_q > SideW'(GRID_SIDE_MAX)) ? SideW'(GRID_SIDE_MAX) : grid_w_q;
    h_sat  = (grid_h_q > SideW'(GRID_SIDE_MAX)) ? SideW'(GRID_SIDE_MAX) : grid_h_q;
    r_sat  = (rad_q > RadW'(VISION_MAX)) ? RadW'(VISION_MAX) : rad_q;
    obs_in_grid = (SideW'(pos_x_i) < w_sat) && (SideW'(pos_y_i) < h_sat);
    px_c   = CoordW'(pos_x_i);
    py_c   = CoordW'(pos_y_i);
    r_c    = CoordW'(r_sat);
    wm1    = CoordW'(w_sat) - CoordW'(1);
    hm1    = CoordW'(h_sat) - CoordW'(1);
    x0_c   = (px_c >= r_c) ? (px_c - r_c) : '0;
    y0_c   = (py_c >= r_c) ? (py_c - r_c) : '0;
    x1_c   = ((px_c + r_c) > wm1) ? wm1 : (px_c + r_c);
    y1_c   = ((py_c + r_c) > hm1) ? hm1 : (py_c + r_c);
  end

  logic [PosW-1:0]   px_q, py_q, x0_q, x1_q, y1_q, cx_q, cy_q;
  logic [2*RadW-1:0] rsq_q;
  logic              walk_last;

  assign walk_last = (cx_q == x1_q) && (cy_q == y1_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_scan) begin
      px_q  <= pos_x_i;
      py_q  <= pos_y_i;
      x0_q  <= x0_c[PosW-1:0];
      x1_q  <= x1_c[PosW-1:0];
      y1_q  <= y1_c[PosW-1:0];
      cx_q  <= x0_c[PosW-1:0];
      cy_q  <= y0_c[PosW-1:0];
      rsq_q <= (2*RadW)'(r_sat) * (2*RadW)'(r_sat);
    end else if (cmd_i.step) begin
      // row-major walk
      if (cx_q == x1_q) begin
        cx_q <= x0_q;
        cy_q <= cy_q + PosW'(1);
      end else begin
        cx_q <= cx_q + PosW'(1);
      end
    end
  end

  // distance test of the current cell
  logic signed [PosW:0]  dx, dy;
  logic signed [SqW-1:0] dx2, dy2;
  logic [CmpW-1:0]       dsq;
  logic                  in_rad;

  always_comb begin
    dx     = $signed({1'b0, cx_q}) - $signed({1'b0, px_q});
    dy     = $signed({1'b0, cy_q}) - $signed({1'b0, py_q});
    dx2    = SqW'(dx) * SqW'(dx);
    dy2    = SqW'(dy) * SqW'(dy);
    dsq    = CmpW'($unsigned(dx2)) + CmpW'($unsigned(dy2));
    in_rad = (dsq <= CmpW'(rsq_q));
  end

  // grid memory, one write and one registered read per cycle
  logic [CellW-1:0] mem [Depth];
  logic [CellW-1:0] mem_rd_q, cell_wr, mem_wdata;
  logic [AddrW-1:0] clr_cnt_q, wr_addr, rd_addr, mem_waddr;
  logic             wr_ok, mem_we;

  always_comb begin
    wr_ok     = (SideW'(pos_x_i) < SideW'(GRID_SIDE_MAX)) &&
                (SideW'(pos_y_i) < SideW'(GRID_SIDE_MAX));
    wr_addr   = AddrW'(pos_y_i) * AddrW'(GRID_SIDE_MAX) + AddrW'(pos_x_i);
    rd_addr   = AddrW'(cy_q) * AddrW'(GRID_SIDE_MAX) + AddrW'(cx_q);
    // negative entity id empties the cell
    cell_wr   = cell_entity_i[ID_BITS] ? '0
                                       : {1'b1, cell_entity_i[ID_BITS-1:0], cell_team_i};
    mem_we    = cmd_i.clear || (cmd_i.write_cell && wr_ok);
    mem_waddr = cmd_i.clear ? clr_cnt_q : wr_addr;
    mem_wdata = cmd_i.clear ? '0 : cell_wr;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear) begin
      clr_cnt_q <= clr_cnt_q + AddrW'(1);
    end
  end

  // hit test and one-deep pending result so the final one can be marked
  logic               rd_vld_q, rd_last_q, end_q, pend_vld_q, out_vld_q;
  logic               pend_vld_d, out_vld_d, out_last_d;
  logic [ID_BITS-1:0] pend_id_q, pend_id_d, out_id_q, out_sender_q;
  logic               out_last_q;
  logic [ID_BITS-1:0] rd_id;
  logic               hit;

  always_comb begin
    rd_id      = mem_rd_q[TEAM_BITS +: ID_BITS];
    hit        = rd_vld_q && mem_rd_q[CellW-1] && (rd_id != own_id_q) &&
                 (mem_rd_q[TEAM_BITS-1:0] != own_team_q);
    pend_vld_d = pend_vld_q;
    pend_id_d  = pend_id_q;
    out_vld_d  = 1'b0;
    out_last_d = 1'b0;
    if (hit) begin
      out_vld_d  = pend_vld_q;
      pend_vld_d = 1'b1;
      pend_id_d  = rd_id;
    end else if (end_q) begin
      out_vld_d  = pend_vld_q;
      out_last_d = 1'b1;
      pend_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q   <= 1'b0;
      rd_last_q  <= 1'b0;
      end_q      <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      rd_vld_q   <= cmd_i.step && in_rad;
      rd_last_q  <= cmd_i.step && walk_last;
      end_q      <= rd_last_q;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_id_q    <= pend_id_d;
    out_id_q     <= pend_id_q;
    out_sender_q <= own_id_q;
    out_last_q   <= out_last_d;
  end

  always_comb begin
    sts_o.clear_done  = (clr_cnt_q == AddrW'(Depth - 1));
    sts_o.scan_inside = obs_in_grid;
    sts_o.walk_last   = walk_last;
    sts_o.scan_end    = end_q;
  end

  assign valid_o     = out_vld_q;
  assign enemy_id_o  = out_id_q;
  assign sender_id_o = out_sender_q;
  assign last_o      = out_last_q;

  `GRES_ASSERT_IMPL(a_end_no_read, end_q, !rd_vld_q)
  `GRES_ASSERT_NEXT(a_end_flushes, end_q, !pend_vld_q)
  `GRES_ASSERT_NEXT(a_last_gap, out_vld_q && out_last_q, !out_vld_q)
  `GRES_ASSERT_IMPL(a_walk_window, cmd_i.step, (cy_q <= y1_q) && (cx_q <= x1_q))

endmodule

// File: sv/grid_radius_enemy_scan_top.sv
// a write request, or a scan from outside the grid, is taken without raising busy; a scan
// walks its clamped window one cell a cycle, then drains through rd_last_q and end_q, busy
// high over all of it (up to 81 cells at radius 4); at most one result a cycle, the last
// on the cycle busy drops; no result stalls; a write per cycle, a new scan once busy drops
// reset: config registers return to defaults and the grid is cleared one cell a cycle over
// all GRID_SIDE_MAX squared cells (4096) with busy high; config writes are taken throughout
module grid_radius_enemy_scan_top
  import gres_pkg::*;
#(
  parameter int unsigned GRID_SIDE_MAX = GRID_SIDE_MAX_DEF,
  parameter int unsigned ID_BITS       = ID_BITS_DEF,
  parameter int unsigned TEAM_BITS     = TEAM_BITS_DEF,
  parameter int unsigned VISION_MAX    = VISION_MAX_DEF,
  localparam int unsigned PosW = $clog2(GRID_SIDE_MAX),
  localparam int unsigned CfgW = cfg_w(GRID_SIDE_MAX, ID_BITS, TEAM_BITS, VISION_MAX)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CfgW-1:0]         cfg_wdata_i,
  input  logic                    start,
  output logic                    busy,
  input  logic                    command_i,
  input  logic [PosW-1:0]         pos_x_i,
  input  logic [PosW-1:0]         pos_y_i,
  input  logic signed [ID_BITS:0] cell_entity_i,
  input  logic [TEAM_BITS-1:0]    cell_team_i,
  output logic                    valid_o,
  output logic [ID_BITS-1:0]      enemy_id_o,
  output logic [ID_BITS-1:0]      sender_id_o,
  output logic                    last_o
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  gres_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (command_i),
    .sts_i     (dp_sts),
    .cmd_o     (dp_cmd),
    .busy      (busy)
  );

  gres_dp #(
    .GRID_SIDE_MAX (GRID_SIDE_MAX),
    .ID_BITS       (ID_BITS),
    .TEAM_BITS     (TEAM_BITS),
    .VISION_MAX    (VISION_MAX)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dp_cmd),
    .sts_o         (dp_sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .cell_entity_i (cell_entity_i),
    .cell_team_i   (cell_team_i),
    .valid_o       (valid_o),
    .enemy_id_o    (enemy_id_o),
    .sender_id_o   (sender_id_o),
    .last_o        (last_o)
  );

endmodule
